FILE: sv/sgh_pkg.sv
`timescale 1ns / 1ps
package sgh_pkg;

  localparam int unsigned DATA_W = 16;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_in;
  } sgh_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
  } sgh_out_t;

  // One element moving along the chain, or resting in a cell.
  typedef struct packed {
    logic                     vld;
    logic signed [DATA_W-1:0] val;
  } sgh_link_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_EMIT
  } sgh_state_t;

endpackage

FILE: sv/sgh_cell.sv
`timescale 1ns / 1ps
module sgh_cell
  import sgh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      shift,
  input  sgh_link_t link_in,
  input  sgh_link_t nbr_hold,
  output sgh_link_t hold,
  output sgh_link_t pass
);

  sgh_link_t hold_r, hold_nxt;
  sgh_link_t pass_r, pass_nxt;

  // Shift pulls from the right; else keep min, pass max right.
  always_comb begin
    hold_nxt = hold_r;
    pass_nxt = '0;
    if (shift) begin
      hold_nxt = nbr_hold;
    end else if (link_in.vld) begin
      if (!hold_r.vld) begin
        hold_nxt = link_in;
      end else if (hold_r.val > link_in.val) begin
        hold_nxt.val = link_in.val;
        pass_nxt     = hold_r;
      end else begin
        pass_nxt = link_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= '0;
      pass_r <= '0;
    end else begin
      hold_r <= hold_nxt;
      pass_r <= pass_nxt;
    end
  end

  assign hold = hold_r;
  assign pass = pass_r;

endmodule

FILE: sv/shell_sort_gap_halving.sv
`timescale 1ns / 1ps
// Sorting block: collects a set of signed 16-bit values and returns them in
// ascending order.
//
// Input channel (in_valid / in_stall / in_data): one value per transfer,
// the final value of a set carries last_in. Values beyond MAX_ITEMS are
// dropped, but their last_in still closes the set.
// Output channel (out_valid / out_stall / out_data): one sorted value per
// transfer, last_out on the final one.
//
// Operation: while loading, the input takes values back to back. The row of
// MAX_ITEMS cells sorts by insertion as the values stream in; after the
// closing transfer the chain settles (one cell hop per cycle), then the set
// shifts out of cell 0 at one item per cycle while the output is not
// stalled. in_stall is high from the closing transfer until the last result
// has entered the output register and the state machine is back in ST_LOAD.
// Reset empties all cells and the output register. While out_valid and
// out_stall are both high, the output register holds and no value shifts
// out of the cell row.
module shell_sort_gap_halving
  import sgh_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sgh_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sgh_out_t out_data
);

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ITEMS);

  sgh_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_vld_r, out_vld_nxt;
  sgh_out_t         out_data_r, out_data_nxt;

  logic             in_xfer;
  logic             store;
  logic             out_load;
  logic             chain_busy;

  sgh_link_t        link [MAX_ITEMS+1];
  sgh_link_t        hold [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] pass_vld;

  assign in_stall = (state_r != ST_LOAD);
  assign in_xfer  = in_valid && !in_stall;
  // Drop values once the row is full.
  assign store    = in_xfer && (cnt_r != CNT_FULL);

  assign link[0].vld = store;
  assign link[0].val = in_data.value;

  // In ST_EMIT, pull the next result when the output reg is free or drains.
  assign out_load = (state_r == ST_EMIT) && (cnt_r != '0) && (!out_vld_r || !out_stall);

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
      sgh_link_t nbr;
      if (gi == MAX_ITEMS - 1) begin : g_end
        assign nbr = '0;
      end else begin : g_mid
        assign nbr = hold[gi+1];
      end
      sgh_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift    (out_load),
        .link_in  (link[gi]),
        .nbr_hold (nbr),
        .hold     (hold[gi]),
        .pass     (link[gi+1])
      );
      assign pass_vld[gi] = link[gi+1].vld;
    end
  endgenerate

  // Chain is settled once no element is in flight between cells.
  assign chain_busy = |pass_vld;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;

    if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_LOAD: begin
        if (store) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (in_xfer && in_data.last_in) begin
          state_nxt = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        if (!chain_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_vld_nxt               = 1'b1;
          out_data_nxt.sorted_value = hold[0].val;
          out_data_nxt.last_out     = (cnt_r == CNT_W'(1));
          cnt_nxt                   = cnt_r - CNT_W'(1);
        end
        if (cnt_r == '0) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

FILE: sv/sgh_checker.sv
`timescale 1ns / 1ps
module sgh_checker
  import sgh_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input sgh_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input sgh_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last_in |=> in_stall)
    else $error("input taken right after closing transfer");

  a_no_load_mid_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_out |-> in_stall)
    else $error("input open while a set is still going out");

  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_out |=> out_valid)
    else $error("bubble inside a sorted set");

  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_out |=>
      out_data.sorted_value >= $past(out_data.sorted_value))
    else $error("results out of order");

endmodule

bind shell_sort_gap_halving sgh_checker u_sgh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import sgh_pkg::*;

  localparam int unsigned CAPACITY   = 32;
  localparam int unsigned RAND_ITEMS = 160;
  localparam int unsigned MAX_CYCLES = 200000;
  localparam int unsigned DRAIN_WAIT = 150;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  sgh_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sgh_out_t out_data;

  shell_sort_gap_halving #(
    .MAX_ITEMS(CAPACITY)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  sgh_in_t  pending_items[$];
  sgh_out_t sorted_expect[$];

  // Software copy of the sorter state.
  logic signed [DATA_W-1:0] held_vals[CAPACITY];
  int unsigned held_count = 0;

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;

  // Every fourth block of cycles runs with no gaps at all.
  function automatic bit calm_phase();
    return ((cycle_count / 2000) % 4) == 3;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_phase() || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Store one accepted value; on the closing mark, sort the set with
  // halving gaps and queue one expected transfer per element.
  task take_value(input sgh_in_t item);
    int unsigned n;
    int unsigned gap;
    int unsigned lo;
    bit swapped;
    logic signed [DATA_W-1:0] tmp;
    sgh_out_t res;
    if (held_count < CAPACITY) begin
      held_vals[held_count] = item.value;
      held_count++;
    end
    if (item.last_in) begin
      n = held_count;
      gap = n;
      while (gap > 1) begin
        gap = gap / 2;
        swapped = 1'b1;
        while (swapped) begin
          swapped = 1'b0;
          for (lo = 0; lo + gap < n; lo++) begin
            if (held_vals[lo] > held_vals[lo + gap]) begin
              tmp = held_vals[lo];
              held_vals[lo] = held_vals[lo + gap];
              held_vals[lo + gap] = tmp;
              swapped = 1'b1;
            end
          end
        end
      end
      for (lo = 0; lo < n; lo++) begin
        res.sorted_value = held_vals[lo];
        res.last_out = (lo + 1 == n);
        sorted_expect.push_back(res);
      end
      held_count = 0;
    end
  endtask

  task add_item(input logic [DATA_W-1:0] v, input logic last);
    sgh_in_t item;
    item.value = v;
    item.last_in = last;
    pending_items.push_back(item);
  endtask

  // Random set of the given size; some sets draw from a narrow range so
  // that duplicates are common.
  task add_random_set(input int unsigned size);
    int unsigned k;
    bit narrow;
    logic [DATA_W-1:0] v;
    narrow = ($urandom_range(0, 3) == 0);
    for (k = 0; k < size; k++) begin
      if (narrow) v = DATA_W'($urandom_range(0, 6)) - DATA_W'(3);
      else v = DATA_W'($urandom);
      add_item(v, k + 1 == size);
    end
  endtask

  // Driver: hold a stalled transfer, otherwise advance after the gap.
  always @(posedge clk) begin : drive_proc
    logic busy;
    logic nxt_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      send_gap = 0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        take_value(in_data);
        busy = 1'b0;
      end
      if (!busy) begin
        nxt_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          nxt_valid = 1'b1;
          send_gap = pick_gap();
        end
        in_valid <= nxt_valid;
      end
    end
  end

  // Receiver stall: random runs of stall between open stretches.
  always @(posedge clk) begin : stall_proc
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!calm_phase() && $urandom_range(0, 5) == 0) begin
        stall_left = (pick_gap() > 0) ? pick_gap() + 1 : 1;
      end
    end
  end

  // Monitor: compare each output transfer with the oldest expectation.
  always @(posedge clk) begin : check_proc
    sgh_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (sorted_expect.size() == 0) begin
        $display("%0t: unexpected output transfer: value %0d last %0b", $time,
                 out_data.sorted_value, out_data.last_out);
        error_count++;
      end else begin
        want = sorted_expect.pop_front();
        if (out_data.sorted_value !== want.sorted_value) begin
          $display("%0t: sorted_value mismatch: expected %0d, got %0d", $time,
                   want.sorted_value, out_data.sorted_value);
          error_count++;
        end
        if (out_data.last_out !== want.last_out) begin
          $display("%0t: last_out mismatch: expected %0b, got %0b", $time,
                   want.last_out, out_data.last_out);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("shell_sort_gap_halving test failed");
      $finish;
    end
  end

  initial begin : main_proc
    int unsigned queued;
    int unsigned r;
    int unsigned size;

    // Single-element sets at both extremes.
    add_item(16'h8000, 1'b1);
    add_item(16'h7fff, 1'b1);
    // Extremes, zero and minus one in one set.
    add_item(16'h7fff, 1'b0);
    add_item(16'h8000, 1'b0);
    add_item(16'h0000, 1'b0);
    add_item(16'hffff, 1'b1);
    // All equal: no swap may happen.
    add_item(16'h0005, 1'b0);
    add_item(16'h0005, 1'b0);
    add_item(16'h0005, 1'b1);
    // Reverse order.
    add_item(16'd40, 1'b0);
    add_item(16'd30, 1'b0);
    add_item(16'd20, 1'b0);
    add_item(16'd10, 1'b0);
    add_item(16'hfff6, 1'b1);
    // Already in order, two elements.
    add_item(16'hfffe, 1'b0);
    add_item(16'h0001, 1'b1);

    // Random part: one exactly full set and one that overflows, then a mix.
    add_random_set(CAPACITY);
    add_random_set(CAPACITY + 2);
    queued = unsigned'(pending_items.size());
    while (queued < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) size = $urandom_range(CAPACITY - 1, CAPACITY + 4);
      else if (r < 20) size = 1;
      else size = $urandom_range(2, 12);
      add_random_set(size);
      queued += size;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every item is accepted and every result has come.
    while (pending_items.size() > 0 || in_valid) @(posedge clk);
    while (sorted_expect.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_count == 0) begin
      $display("shell_sort_gap_halving test passed");
    end else begin
      $display("shell_sort_gap_halving test failed");
    end
    $finish;
  end

endmodule
